[design/ptp_pkg.sv]
package ptp_pkg;

  // Field and datapath widths.
  localparam int unsigned FEAT_W  = 16;
  localparam int unsigned W_W     = 32;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned GOAL_W  = 2;
  localparam int unsigned PRED_W  = 2;
  localparam int unsigned MUL_A_W = FEAT_W + 1;
  localparam int unsigned MUL_B_W = W_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = PROD_W + 2;

  // Number of feature inputs; weights beyond these see a zero feature.
  localparam int unsigned FEATURE_COUNT = 3;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd655;

  // Class codes on the prediction output.
  localparam logic [PRED_W-1:0] PRED_POS = 2'b01;
  localparam logic [PRED_W-1:0] PRED_NEG = 2'b11;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_CHECK,
    ST_UPD_MUL,
    ST_UPD_WR,
    ST_DONE
  } ptp_state_e;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic in_rdy;
    logic mul_en;
    logic op_upd;
    logic acc_clr;
    logic acc_en;
    logic pred_ld;
    logic w_wr;
    logic out_ld;
  } ptp_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic train;
    logic mismatch;
    logic out_free;
  } ptp_stat_t;

endpackage

[design/ptp_mul.sv]
module ptp_mul (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [ptp_pkg::MUL_A_W-1:0]    a_i,
  input  logic signed [ptp_pkg::MUL_B_W-1:0]    b_i,
  output logic signed [ptp_pkg::PROD_W-1:0]     prod_o
);
  import ptp_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;

  // Shared signed multiplier; the product is registered before use.
  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[design/ptp_seq.sv]
module ptp_seq #(
  parameter int unsigned IDX_W    = 2,
  parameter int unsigned LAST_IDX = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptp_pkg::ptp_stat_t   stat_i,
  output ptp_pkg::ptp_ctrl_t   ctrl_o,
  output logic [IDX_W-1:0]     idx_o
);
  import ptp_pkg::*;

  ptp_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             idx_last;

  assign idx_last = (idx_q == IDX_W'(LAST_IDX));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (stat_i.in_fire) state_d = ST_DOT_MUL;
      ST_DOT_MUL: state_d = ST_DOT_ACC;
      ST_DOT_ACC: state_d = idx_last ? ST_CHECK : ST_DOT_MUL;
      ST_CHECK:   state_d = (stat_i.train && stat_i.mismatch) ? ST_UPD_MUL : ST_DONE;
      ST_UPD_MUL: state_d = ST_UPD_WR;
      ST_UPD_WR:  state_d = idx_last ? ST_DONE : ST_UPD_MUL;
      ST_DONE:    if (stat_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Weight index walks the store once for the dot product and, when the weights are updated, once for the update.
  always_comb begin
    idx_d = idx_q;
    case (state_q)
      ST_IDLE:    idx_d = '0;
      ST_DOT_ACC: idx_d = idx_last ? '0 : idx_q + IDX_W'(1);
      ST_CHECK:   idx_d = '0;
      ST_UPD_WR:  idx_d = idx_last ? '0 : idx_q + IDX_W'(1);
      default:    idx_d = idx_q;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.in_rdy  = 1'b1;
        ctrl_o.acc_clr = 1'b1;
      end
      ST_DOT_MUL: ctrl_o.mul_en = 1'b1;
      ST_DOT_ACC: ctrl_o.acc_en = 1'b1;
      ST_CHECK:   ctrl_o.pred_ld = 1'b1;
      ST_UPD_MUL: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_upd = 1'b1;
      end
      ST_UPD_WR: begin
        ctrl_o.op_upd = 1'b1;
        ctrl_o.w_wr   = 1'b1;
      end
      ST_DONE:    ctrl_o.out_ld = stat_i.out_free;
      default:    ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign idx_o = idx_q;

endmodule

[design/perceptron_train_predict_core.sv]
// The block takes one item at a time: the input is ready only in the idle state, and a new
// item is accepted only after the previous result has been loaded into the output register.
// Each weight takes a multiply and an accumulate step on the shared multiplier, and a
// multiply and a write step more when a misclassified train item updates it.
// A result that is not taken holds the block, and so its input, until it leaves.
// Reset clears all weights to zero, sets the learning rate to 655 and empties the output.
module perceptron_train_predict_core #(
  parameter int unsigned NUM_WEIGHTS = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ptp_pkg::RATE_W-1:0]          learning_rate_i,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic signed [ptp_pkg::FEAT_W-1:0]   feature_0_i,
  input  logic signed [ptp_pkg::FEAT_W-1:0]   feature_1_i,
  input  logic signed [ptp_pkg::FEAT_W-1:0]   feature_2_i,
  input  logic signed [ptp_pkg::GOAL_W-1:0]   goal_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ptp_pkg::PRED_W-1:0]   prediction_o
);
  import ptp_pkg::*;

  localparam int unsigned IDX_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

  ptp_ctrl_t ctrl;
  ptp_stat_t stat;
  logic [IDX_W-1:0] idx;

  logic [RATE_W-1:0]        rate_q;
  logic                     kind_q;
  logic                     goal_neg_q;
  logic signed [FEAT_W-1:0] feat_q [FEATURE_COUNT];
  logic signed [W_W-1:0]    w_q [NUM_WEIGHTS];
  logic signed [ACC_W-1:0]  acc_q;
  logic                     pred_neg_q;
  logic                     out_valid_q;
  logic [PRED_W-1:0]        out_pred_q;

  logic signed [FEAT_W-1:0]  feat_sel;
  logic signed [W_W-1:0]     w_sel;
  logic [FEAT_W:0]           feat_abs;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [MUL_B_W:0]          mag2;
  logic [MUL_B_W+1:0]        mag_rnd;
  logic [W_W:0]              delta;
  logic                      step_neg;
  logic signed [W_W:0]       w_sum;
  logic signed [W_W-1:0]     w_new;
  logic                      in_fire;

  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ready_o  = ctrl.in_rdy;
  assign cfg_ready_o = 1'b1;

  // Learning rate register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_valid_i) begin
      rate_q <= learning_rate_i;
    end
  end

  // Capture the input transaction.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q     <= kind_i;
      goal_neg_q <= goal_i[GOAL_W-1];
      feat_q[0]  <= feature_0_i;
      feat_q[1]  <= feature_1_i;
      feat_q[2]  <= feature_2_i;
    end
  end

  // Feature for the current weight; weights without a feature see zero.
  always_comb begin
    feat_sel = '0;
    if (32'(idx) == 32'd0) begin
      feat_sel = feat_q[0];
    end else if (32'(idx) == 32'd1) begin
      feat_sel = feat_q[1];
    end else if (32'(idx) == 32'd2) begin
      feat_sel = feat_q[2];
    end
  end

  assign w_sel    = w_q[idx];
  assign feat_abs = feat_sel[FEAT_W-1] ? (FEAT_W+1)'(-(FEAT_W+1)'(feat_sel))
                                       : (FEAT_W+1)'(feat_sel);

  // Operand select for the shared multiplier: feature*weight or rate*|feature|.
  always_comb begin
    if (ctrl.op_upd) begin
      mul_a = MUL_A_W'({1'b0, rate_q});
      mul_b = MUL_B_W'(feat_abs);
    end else begin
      mul_a = MUL_A_W'(feat_sel);
      mul_b = MUL_B_W'(w_sel);
    end
  end

  ptp_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Dot product accumulator.
  always_ff @(posedge clk_i) begin
    if (ctrl.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod);
    end
  end

  // Update step: round rate*|x|*2 to 16 fractional bits, then apply the sign.
  assign mag2     = {prod[MUL_B_W-1:0], 1'b0};
  assign mag_rnd  = (MUL_B_W+2)'(mag2) + (MUL_B_W+2)'(128);
  assign delta    = (W_W+1)'(mag_rnd[MUL_B_W+1:8]);
  assign step_neg = feat_sel[FEAT_W-1] != goal_neg_q;
  assign w_sum    = step_neg ? ((W_W+1)'(w_sel) - signed'(delta))
                             : ((W_W+1)'(w_sel) + signed'(delta));

  // Saturate to the weight range.
  always_comb begin
    if (w_sum[W_W] != w_sum[W_W-1]) begin
      w_new = w_sum[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
    end else begin
      w_new = w_sum[W_W-1:0];
    end
  end

  // Weight store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        w_q[i] <= '0;
      end
    end else if (ctrl.w_wr) begin
      w_q[idx] <= w_new;
    end
  end

  // Prediction taken from the sign of the finished sum.
  always_ff @(posedge clk_i) begin
    if (ctrl.pred_ld) begin
      pred_neg_q <= acc_q[ACC_W-1];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_ld) begin
      out_pred_q <= pred_neg_q ? PRED_NEG : PRED_POS;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign prediction_o = out_pred_q;

  // Status to the sequencer.
  assign stat.in_fire  = in_fire;
  assign stat.train    = kind_q;
  assign stat.mismatch = goal_neg_q != acc_q[ACC_W-1];
  assign stat.out_free = !out_valid_q || out_ready_i;

  ptp_seq #(
    .IDX_W    (IDX_W),
    .LAST_IDX (NUM_WEIGHTS - 1)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .idx_o  (idx)
  );

endmodule

[test/perceptron_train_predict_core_tb.sv]
module perceptron_train_predict_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptp_pkg::*;

  // Item kinds and goal encodings on the input channel.
  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_TRAIN   = 1'b1;
  localparam logic [GOAL_W-1:0] GOAL_POS    = 2'b01;
  localparam logic [GOAL_W-1:0] GOAL_NEG    = 2'b11;
  localparam logic [GOAL_W-1:0] GOAL_ZERO   = 2'b00;
  localparam logic [GOAL_W-1:0] GOAL_MINUS2 = 2'b10;

  localparam int unsigned NUM_W       = 3;
  localparam int unsigned MAX_GAP     = 6;
  localparam int unsigned SETTLE_CYC  = 4 * NUM_W + 6;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam longint      W_HI        = 64'sd2147483647;
  localparam longint      W_LO        = -64'sd2147483648;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [RATE_W-1:0]        learning_rate_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     kind_i;
  logic signed [FEAT_W-1:0] feature_0_i;
  logic signed [FEAT_W-1:0] feature_1_i;
  logic signed [FEAT_W-1:0] feature_2_i;
  logic signed [GOAL_W-1:0] goal_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [PRED_W-1:0] prediction_o;

  // Shadow copy of the block state.
  logic signed [W_W-1:0] model_weight [NUM_W];
  logic [RATE_W-1:0]     model_rate;

  logic [PRED_W-1:0] expected_class_q [$];
  int unsigned       fail_count;
  logic              idle_on;
  logic              hold_request;

  perceptron_train_predict_core #(
    .NUM_WEIGHTS(NUM_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .learning_rate_i(learning_rate_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .feature_0_i    (feature_0_i),
    .feature_1_i    (feature_1_i),
    .feature_2_i    (feature_2_i),
    .goal_i         (goal_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .prediction_o   (prediction_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Classify one item with the current weights, then apply the learning rule
  // when it is a training item that was misclassified.
  function automatic logic [PRED_W-1:0] classify_and_learn(
    input logic kind, input logic signed [FEAT_W-1:0] f0,
    input logic signed [FEAT_W-1:0] f1, input logic signed [FEAT_W-1:0] f2,
    input logic [GOAL_W-1:0] goal);
    longint x [NUM_W];
    longint dot;
    longint ax;
    longint mag;
    longint updated;
    logic   class_neg;
    logic   goal_neg;
    logic   step_down;
    x[0] = longint'(f0);
    x[1] = longint'(f1);
    x[2] = longint'(f2);
    dot = 0;
    for (int i = 0; i < NUM_W; i++) begin
      dot += x[i] * longint'(model_weight[i]);
    end
    class_neg = (dot < 0);
    // Only the sign bit of the goal matters.
    goal_neg = goal[GOAL_W-1];
    if (kind == KIND_TRAIN && goal_neg != class_neg) begin
      for (int i = 0; i < NUM_W; i++) begin
        ax = (x[i] < 0) ? -x[i] : x[i];
        mag = (longint'(model_rate) * ax * 2 + 128) >>> 8;
        step_down = (x[i] < 0) != goal_neg;
        updated = longint'(model_weight[i]) + (step_down ? -mag : mag);
        if (updated > W_HI) updated = W_HI;
        if (updated < W_LO) updated = W_LO;
        model_weight[i] = updated[W_W-1:0];
      end
    end
    return class_neg ? PRED_NEG : PRED_POS;
  endfunction

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Offer one item; entered and left at a falling edge.
  task automatic send_item(input logic kind, input logic signed [FEAT_W-1:0] f0,
                           input logic signed [FEAT_W-1:0] f1,
                           input logic signed [FEAT_W-1:0] f2,
                           input logic [GOAL_W-1:0] goal);
    int unsigned       gap;
    logic [PRED_W-1:0] want;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    feature_0_i <= f0;
    feature_1_i <= f1;
    feature_2_i <= f2;
    goal_i      <= goal;
    do @(posedge clk_i); while (!in_ready_o);
    want = classify_and_learn(kind, f0, f1, f2, goal);
    expected_class_q = {expected_class_q, want};
    @(negedge clk_i);
  endtask

  // Wait until every expected result has come back and the block is quiet.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_class_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_learning_rate(input logic [RATE_W-1:0] value);
    cfg_valid_i     <= 1'b1;
    learning_rate_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_rate = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Feature values weighted toward the extremes and toward small magnitudes.
  function automatic logic signed [FEAT_W-1:0] pick_feature();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3, 4: return FEAT_W'($urandom_range(0, 2047)) - 16'd1024;
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  task automatic test_directed_items();
    idle_on = 1'b1;
    send_item(KIND_PREDICT, 16'sd0, 16'sd0, 16'sd0, GOAL_POS);
    send_item(KIND_TRAIN, 16'sd256, 16'sd0, 16'sd0, GOAL_NEG);
    send_item(KIND_PREDICT, 16'sd256, 16'sd0, 16'sd0, GOAL_POS);
    send_item(KIND_TRAIN, 16'sd256, 16'sd0, 16'sd0, GOAL_POS);
    send_item(KIND_TRAIN, 16'sh7fff, 16'sh8000, 16'sd0, GOAL_ZERO);
    send_item(KIND_TRAIN, 16'sh8000, 16'sh7fff, 16'sh8000, GOAL_MINUS2);
    send_item(KIND_TRAIN, 16'sh7fff, 16'sh7fff, 16'sh7fff, GOAL_POS);
    send_item(KIND_PREDICT, 16'sh8000, 16'sh8000, 16'sh8000, GOAL_NEG);
    // All-zero features give a zero step even when misclassified.
    send_item(KIND_TRAIN, 16'sd0, 16'sd0, 16'sd0, GOAL_NEG);
    send_item(KIND_TRAIN, 16'sd1, -16'sd1, 16'sd0, GOAL_NEG);
    send_item(KIND_PREDICT, 16'sh7fff, 16'sh8000, 16'sh7fff, GOAL_MINUS2);
    // The same item twice; the second sees the weights left by the first.
    send_item(KIND_TRAIN, 16'sd256, 16'sd256, 16'sd256, GOAL_POS);
    send_item(KIND_TRAIN, 16'sd256, 16'sd256, 16'sd256, GOAL_POS);
  endtask

  task automatic test_rate_extremes();
    drain_results();
    write_learning_rate('0);
    send_item(KIND_TRAIN, 16'sh8000, 16'sh7fff, 16'sd256, GOAL_NEG);
    send_item(KIND_TRAIN, 16'sh7fff, 16'sh8000, -16'sd256, GOAL_POS);
    drain_results();
    write_learning_rate('1);
    send_item(KIND_TRAIN, 16'sh8000, 16'sh8000, 16'sh7fff, GOAL_POS);
    send_item(KIND_TRAIN, 16'sh7fff, 16'sh8000, 16'sh7fff, GOAL_NEG);
    send_item(KIND_PREDICT, 16'sh7fff, 16'sh7fff, 16'sh8000, GOAL_POS);
    drain_results();
    // A rate of one puts the rounding right on its half-way point.
    write_learning_rate(16'd1);
    send_item(KIND_TRAIN, 16'sd64, -16'sd64, 16'sd63, GOAL_NEG);
    send_item(KIND_TRAIN, 16'sd192, -16'sd191, 16'sd1, GOAL_POS);
    send_item(KIND_TRAIN, -16'sd64, 16'sd64, -16'sd65, GOAL_NEG);
  endtask

  // Phases of mostly training items labeled by a hidden linear separator.
  task automatic test_random_training();
    logic [RATE_W-1:0]        rate_plan [4];
    int                       teacher [NUM_W];
    logic signed [FEAT_W-1:0] f [NUM_W];
    logic [GOAL_W-1:0]        goal;
    logic                     kind;
    longint                   score;
    rate_plan[0] = 16'hffff;
    rate_plan[1] = RATE_W'($urandom);
    rate_plan[2] = RATE_RESET;
    rate_plan[3] = RATE_W'($urandom_range(1, 4000));
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      write_learning_rate(rate_plan[phase]);
      idle_on = (phase != 1);
      for (int i = 0; i < NUM_W; i++) begin
        teacher[i] = $urandom_range(0, 16) - 8;
      end
      for (int n = 0; n < 100; n++) begin
        for (int i = 0; i < NUM_W; i++) begin
          f[i] = pick_feature();
        end
        if ($urandom_range(0, 1) != 0) begin
          f[0] = 16'sd256;
        end
        score = 0;
        for (int i = 0; i < NUM_W; i++) begin
          score += longint'(teacher[i]) * longint'(f[i]);
        end
        goal = (score >= 0) ? GOAL_POS : GOAL_NEG;
        if ($urandom_range(0, 5) == 0) begin
          goal = GOAL_W'($urandom_range(0, 3));
        end
        kind = ($urandom_range(0, 3) != 0) ? KIND_TRAIN : KIND_PREDICT;
        send_item(kind, f[0], f[1], f[2], goal);
      end
    end
  endtask

  // The sink holds off for a long stretch while items keep coming.
  task automatic test_output_backpressure();
    drain_results();
    write_learning_rate(RATE_W'($urandom));
    idle_on = 1'b1;
    hold_request = 1'b1;
    for (int n = 0; n < 25; n++) begin
      send_item(($urandom_range(0, 1) != 0) ? KIND_TRAIN : KIND_PREDICT,
                pick_feature(), pick_feature(), pick_feature(),
                GOAL_W'($urandom_range(0, 3)));
    end
  endtask

  // Result sink: a random stall before each transaction, or a long hold on request.
  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Compare each returned class with the oldest expectation.
  always @(posedge clk_i) begin : class_check
    logic [PRED_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_class_q.size() == 0) begin
        flag_failure($sformatf("Unexpected result: prediction %b", prediction_o));
      end else begin
        want = expected_class_q.pop_front();
        if (prediction_o !== want) begin
          flag_failure($sformatf("Mismatch: prediction expected %b, actual %b",
                                 want, prediction_o));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    learning_rate_i = RATE_RESET;
    in_valid_i      = 1'b0;
    kind_i          = KIND_PREDICT;
    feature_0_i     = '0;
    feature_1_i     = '0;
    feature_2_i     = '0;
    goal_i          = GOAL_POS;
    idle_on         = 1'b1;
    hold_request    = 1'b0;
    fail_count      = 0;
    model_rate      = RATE_RESET;
    for (int i = 0; i < NUM_W; i++) begin
      model_weight[i] = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_items();
    test_rate_extremes();
    test_random_training();
    test_output_backpressure();

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && expected_class_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
